// ----- hdl/pwag_pkg.sv -----
`timescale 1ns / 1ps
package pwag_pkg;

    // default geometry
    localparam int IMG_WIDTH_DEF  = 2048;
    localparam int IMG_HEIGHT_DEF = 2048;
    localparam int BANDS_DEF      = 3;
    localparam int ZOOM_SHIFT_DEF = 1;

    localparam logic [63:0] ONE_Q40 = 64'h0000_0100_0000_0000;

    // quotient bits produced by the divider
    localparam int QBITS = 17;

    typedef enum logic [2:0] {
        CFG_A11 = 3'd0,
        CFG_A12 = 3'd1,
        CFG_A13 = 3'd2,
        CFG_A21 = 3'd3,
        CFG_A22 = 3'd4,
        CFG_A23 = 3'd5,
        CFG_A31 = 3'd6,
        CFG_A32 = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [39:0] map_x;
        logic signed [39:0] map_y;
        logic [1:0]         band_sel;
    } in_item_t;

    typedef struct packed {
        logic        in_image;
        logic [10:0] src_col;
        logic [10:0] src_row;
        logic [23:0] src_addr;
        logic        denom_zero;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [39:0] xm;
        logic        xn;
        logic [39:0] ym;
        logic        yn;
        logic [1:0]  band;
    } fq_item_t;

    typedef struct packed {
        logic signed [63:0] a11;
        logic signed [63:0] a12;
        logic signed [63:0] a13;
        logic signed [63:0] a21;
        logic signed [63:0] a22;
        logic signed [63:0] a23;
        logic signed [63:0] a31;
        logic signed [63:0] a32;
    } coef_set_t;

endpackage

// ----- hdl/pwag_front.sv -----
`timescale 1ns / 1ps
module pwag_front #(
    parameter int BANDS = pwag_pkg::BANDS_DEF
) (
    input  pwag_pkg::in_item_t item,
    output pwag_pkg::fq_item_t cls
);
    import pwag_pkg::*;

    always_comb
    begin
        cls.xn = item.map_x[39];
        cls.yn = item.map_y[39];
        cls.xm = item.map_x[39] ? (~item.map_x + 40'd1) : item.map_x;
        cls.ym = item.map_y[39] ? (~item.map_y + 40'd1) : item.map_y;
        // saturate band to the last one present
        if (5'(item.band_sel) >= 5'(BANDS))
        begin
            cls.band = 2'(BANDS - 1);
        end
        else
        begin
            cls.band = item.band_sel;
        end
    end

endmodule

// ----- hdl/pwag_queue.sv -----
`timescale 1ns / 1ps
module pwag_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pwag_pkg::fq_item_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               avail,
    output pwag_pkg::fq_item_t rdata
);
    import pwag_pkg::*;

    localparam int QD = 4;
    localparam int PTRW = $clog2(QD);

    fq_item_t          mem_reg [0:QD-1];
    logic [PTRW-1:0]   wp_reg, rp_reg;
    logic [PTRW:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (PTRW+1)'(QD));
    assign avail = (cnt_reg != '0);
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/pwag_back.sv -----
`timescale 1ns / 1ps
module pwag_back #(
    parameter int IMG_WIDTH  = pwag_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = pwag_pkg::IMG_HEIGHT_DEF,
    parameter int BANDS      = pwag_pkg::BANDS_DEF,
    parameter int ZOOM_SHIFT = pwag_pkg::ZOOM_SHIFT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pwag_pkg::coef_set_t coef,
    input  logic                q_avail,
    input  pwag_pkg::fq_item_t  q_data,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_ready,
    output pwag_pkg::out_item_t result
);
    import pwag_pkg::*;

    localparam int PW = 107;                 // signed width of A, B, C
    localparam int NW = PW + 18 + ZOOM_SHIFT; // scaled numerator width
    localparam int HALF_C = (IMG_WIDTH >> ZOOM_SHIFT) >> 1;
    localparam int HALF_R = (IMG_HEIGHT >> ZOOM_SHIFT) >> 1;
    localparam logic signed [17:0] HALF_CS = 18'(HALF_C);
    localparam logic signed [17:0] HALF_RS = 18'(HALF_R);
    localparam int NP = 6;
    localparam int AW = 48;

    logic en;
    assign en    = !result_valid || result_ready;
    assign q_pop = en && q_avail;

    // ---------------- stage 0: partial products
    logic [63:0] cm [0:NP-1];
    logic        cs [0:NP-1];
    logic [39:0] vm [0:NP-1];
    logic        vs [0:NP-1];
    logic [51:0] pp_reg [0:NP-1][0:3];
    logic        ng_reg [0:NP-1];
    logic        v0_reg;
    logic [1:0]  b0_reg;

    always_comb
    begin
        cs[0] = coef.a11[63]; cm[0] = coef.a11[63] ? -coef.a11 : coef.a11;
        cs[1] = coef.a12[63]; cm[1] = coef.a12[63] ? -coef.a12 : coef.a12;
        cs[2] = coef.a21[63]; cm[2] = coef.a21[63] ? -coef.a21 : coef.a21;
        cs[3] = coef.a22[63]; cm[3] = coef.a22[63] ? -coef.a22 : coef.a22;
        cs[4] = coef.a31[63]; cm[4] = coef.a31[63] ? -coef.a31 : coef.a31;
        cs[5] = coef.a32[63]; cm[5] = coef.a32[63] ? -coef.a32 : coef.a32;
        for (int i = 0; i < NP; i++)
        begin
            vm[i] = (i % 2 == 0) ? q_data.xm : q_data.ym;
            vs[i] = (i % 2 == 0) ? q_data.xn : q_data.yn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg <= q_data.band;
            for (int i = 0; i < NP; i++)
            begin
                pp_reg[i][0] <= 52'(cm[i][63:32]) * 52'(vm[i][39:20]);
                pp_reg[i][1] <= 52'(cm[i][63:32]) * 52'(vm[i][19:0]);
                pp_reg[i][2] <= 52'(cm[i][31:0]) * 52'(vm[i][39:20]);
                pp_reg[i][3] <= 52'(cm[i][31:0]) * 52'(vm[i][19:0]);
                ng_reg[i]    <= cs[i] ^ vs[i];
            end
        end
    end

    // ---------------- stage 1: signed products
    logic signed [PW-1:0] p_reg [0:NP-1];
    logic [103:0]         mag [0:NP-1];
    logic                 v1_reg;
    logic [1:0]           b1_reg;

    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            mag[i] = (104'(pp_reg[i][0]) << 52) + (104'(pp_reg[i][1]) << 32)
                   + (104'(pp_reg[i][2]) << 20) + 104'(pp_reg[i][3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg <= b0_reg;
            for (int i = 0; i < NP; i++)
            begin
                p_reg[i] <= ng_reg[i] ? -$signed(PW'(mag[i])) : $signed(PW'(mag[i]));
            end
        end
    end

    // ---------------- stage 2: sums
    logic signed [PW-1:0] a_reg, bn_reg, d_reg;
    logic                 v2_reg;
    logic [1:0]           b2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_reg <= b1_reg;
            a_reg  <= p_reg[0] + p_reg[1] + (PW'(coef.a13) <<< 16);
            bn_reg <= p_reg[2] + p_reg[3] + (PW'(coef.a23) <<< 16);
            d_reg  <= p_reg[4] + p_reg[5] + (PW'(1) <<< 56);
        end
    end

    // ---------------- stage 3: offset and scale
    logic signed [NW-1:0] nc_reg, nr_reg;
    logic signed [PW-1:0] d3_reg;
    logic                 v3_reg;
    logic [1:0]           b3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_reg <= b2_reg;
            d3_reg <= d_reg;
            nc_reg <= (NW'(a_reg) + NW'(d_reg) * HALF_CS) <<< ZOOM_SHIFT;
            nr_reg <= (NW'(bn_reg) + NW'(d_reg) * HALF_RS) <<< ZOOM_SHIFT;
        end
    end

    // ---------------- stage 4 and divider stages
    logic [NW-1:0]    rc_reg [0:QBITS];
    logic [NW-1:0]    rr_reg [0:QBITS];
    logic [PW-1:0]    dm_reg [0:QBITS];
    logic [QBITS-1:0] qc_reg [0:QBITS];
    logic [QBITS-1:0] qr_reg [0:QBITS];
    logic             okc_reg [0:QBITS];
    logic             okr_reg [0:QBITS];
    logic             dz_reg [0:QBITS];
    logic [1:0]       bd_reg [0:QBITS];
    logic             dv_reg [0:QBITS];

    logic          dneg, ncneg, nrneg;
    logic [PW-1:0] dmag;
    logic [NW-1:0] ncm, nrm, dlim;

    always_comb
    begin
        dneg  = d3_reg[PW-1];
        ncneg = nc_reg[NW-1];
        nrneg = nr_reg[NW-1];
        dmag  = dneg ? -d3_reg : d3_reg;
        ncm   = ncneg ? -nc_reg : nc_reg;
        nrm   = nrneg ? -nr_reg : nr_reg;
        dlim  = NW'(dmag) << QBITS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_reg[0]  <= ncm;
            rr_reg[0]  <= nrm;
            dm_reg[0]  <= dmag;
            qc_reg[0]  <= '0;
            qr_reg[0]  <= '0;
            dz_reg[0]  <= (d3_reg == '0);
            bd_reg[0]  <= b3_reg;
            okc_reg[0] <= (nc_reg != '0) && (ncneg == dneg) && (ncm < dlim);
            okr_reg[0] <= (nr_reg != '0) && (nrneg == dneg) && (nrm < dlim);
        end
    end

    for (genvar k = 0; k < QBITS; k++)
    begin : g_div
        localparam int B = QBITS - 1 - k;
        logic [NW-1:0] t;
        logic          gec, ger;

        always_comb
        begin
            t   = NW'(dm_reg[k]) << B;
            gec = (rc_reg[k] >= t);
            ger = (rr_reg[k] >= t);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rc_reg[k+1]  <= gec ? (rc_reg[k] - t) : rc_reg[k];
                rr_reg[k+1]  <= ger ? (rr_reg[k] - t) : rr_reg[k];
                qc_reg[k+1]  <= qc_reg[k] | (QBITS'(gec) << B);
                qr_reg[k+1]  <= qr_reg[k] | (QBITS'(ger) << B);
                dm_reg[k+1]  <= dm_reg[k];
                okc_reg[k+1] <= okc_reg[k];
                okr_reg[k+1] <= okr_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
                bd_reg[k+1]  <= bd_reg[k];
            end
        end
    end

    // ---------------- output stage
    logic [QBITS-1:0] qc, qr;
    logic             ok;
    logic [AW-1:0]    addr;
    logic             ov_reg;
    out_item_t        res_reg;

    always_comb
    begin
        qc = qc_reg[QBITS];
        qr = qr_reg[QBITS];
        ok = okc_reg[QBITS] && okr_reg[QBITS] && !dz_reg[QBITS]
          && (qc != '0) && ((QBITS+1)'(qc) < (QBITS+1)'(IMG_WIDTH))
          && (qr != '0) && ((QBITS+1)'(qr) < (QBITS+1)'(IMG_HEIGHT));
        addr = ((AW'(qr) * AW'(BANDS)) + AW'(bd_reg[QBITS])) * AW'(IMG_WIDTH) + AW'(qc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.in_image   <= ok;
            res_reg.src_col    <= ok ? qc[10:0] : 11'd0;
            res_reg.src_row    <= ok ? qr[10:0] : 11'd0;
            res_reg.src_addr   <= ok ? addr[23:0] : 24'd0;
            res_reg.denom_zero <= dz_reg[QBITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= q_avail;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            ov_reg    <= dv_reg[QBITS];
        end
    end

    assign result_valid = ov_reg;
    assign result       = res_reg;

    a_dz_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.denom_zero |-> !result.in_image)
        else $error("zero denominator reported as inside image");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.in_image |->
        (result.src_addr == 24'd0) && (result.src_col == 11'd0) && (result.src_row == 11'd0))
        else $error("invalid result carries nonzero position");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !en |=> v3_reg && $stable(nc_reg))
        else $error("pipeline moved while output stalled");

endmodule

// ----- hdl/projective_warp_address_gen_unit.sv -----
`timescale 1ns / 1ps
// items pass the queue, stages 0 to 4, 17 divider stages and the output register
// throughput: one item per cycle unless stalled; multiply and divider are fully pipelined
// a 4-entry queue between front and back accepts input during output stalls until it fills
// reset: asynchronous active low; clears all valid state and loads identity coefficients
module projective_warp_address_gen_unit #(
    parameter int IMG_WIDTH  = pwag_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = pwag_pkg::IMG_HEIGHT_DEF,
    parameter int BANDS      = pwag_pkg::BANDS_DEF,
    parameter int ZOOM_SHIFT = pwag_pkg::ZOOM_SHIFT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // input item channel
    input  logic                item_valid,
    output logic                item_ready,
    input  pwag_pkg::in_item_t  item,
    // result channel
    output logic                result_valid,
    input  logic                result_ready,
    output pwag_pkg::out_item_t result,
    // coefficient write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import pwag_pkg::*;

    coef_set_t coef_reg;
    fq_item_t  cls, q_data;
    logic      q_full, q_avail, q_pop, push;

    // coefficient writes are always accepted and take effect at the next clock edge
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.a11 <= ONE_Q40;
            coef_reg.a12 <= '0;
            coef_reg.a13 <= '0;
            coef_reg.a21 <= '0;
            coef_reg.a22 <= ONE_Q40;
            coef_reg.a23 <= '0;
            coef_reg.a31 <= '0;
            coef_reg.a32 <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_A11: coef_reg.a11 <= cfg_data;
                CFG_A12: coef_reg.a12 <= cfg_data;
                CFG_A13: coef_reg.a13 <= cfg_data;
                CFG_A21: coef_reg.a21 <= cfg_data;
                CFG_A22: coef_reg.a22 <= cfg_data;
                CFG_A23: coef_reg.a23 <= cfg_data;
                CFG_A31: coef_reg.a31 <= cfg_data;
                CFG_A32: coef_reg.a32 <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: sign/magnitude split and band saturation
    pwag_front #(
        .BANDS(BANDS)
    ) u_front (
        .item(item),
        .cls (cls)
    );

    // accept whenever the queue has room
    assign item_ready = !q_full;
    assign push       = item_valid && item_ready;

    pwag_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(cls),
        .full (q_full),
        .pop  (q_pop),
        .avail(q_avail),
        .rdata(q_data)
    );

    // back: transform, divide, range check, address
    pwag_back #(
        .IMG_WIDTH (IMG_WIDTH),
        .IMG_HEIGHT(IMG_HEIGHT),
        .BANDS     (BANDS),
        .ZOOM_SHIFT(ZOOM_SHIFT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef        (coef_reg),
        .q_avail     (q_avail),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule
